/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence on the same edge.
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/xrr_pkg.sv */
// ----------------------------------------------------------------------------
// xrr_pkg
// Types, constants and command structs for the xorshift128+ range generator.
// ----------------------------------------------------------------------------
`default_nettype none
package xrr_pkg;
  localparam logic [63:0] SEED_FIRST  = 64'h5229a30f996ad7eb;
  localparam logic [63:0] SEED_SECOND = 64'hc03bbc753f671f6f;
  localparam int FRAC_BITS = 53;
  localparam int SHIFT_A = 23;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 26;
  localparam int DIV_W = 64;

  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_UNIT   = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_STEP = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  localparam logic [0:0] CFG_SEED_LOW  = 1'b0;
  localparam logic [0:0] CFG_SEED_HIGH = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] range_start;
    logic signed [63:0] range_end;
    logic signed [63:0] range_step;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } out_item_t;

  // Divider operand source selects.
  typedef enum logic [1:0] {
    DSRC_COUNT,  // span / |step|
    DSRC_SCALE,  // all-ones / count
    DSRC_PICK    // draw / a
  } dsrc_t;

  // Result selects.
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_UNIT,
    RES_MASK,
    RES_SCALED,
    RES_ZSTEP,
    RES_EMPTY
  } rsel_t;

  typedef struct packed {
    logic  load;      // capture input item
    logic  reseed;
    logic  draw;      // advance generator, keep output
    logic  div_start;
    dsrc_t div_src;
    logic  count_cap; // capture count from quotient
    logic  a_cap;     // capture a from quotient
    logic  lim_cap;   // capture a*count
    logic  mul_start; // start quotient times step
    logic  res_cap;
    rsel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       step_zero;
    logic       count_zero;
    logic       pow2_unit;
    logic       div_done;
    logic       mul_done;
    logic       reject;
  } stat_t;
endpackage
`default_nettype wire

/* rtl/xrr_div.sv */
// ----------------------------------------------------------------------------
// xrr_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module xrr_div #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder,
  output logic              rem_nz
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] dvs;
  logic [W-1:0] rem;
  logic [CW-1:0] cnt;
  logic busy;
  logic [W:0] trial;
  logic [W:0] diff;

  assign trial = {rem, quotient[W-1]};
  assign diff = trial - {1'b0, dvs};
  assign rem_nz = |rem;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(W);
        quotient <= dividend;
        dvs <= divisor;
        rem <= '0;
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          rem <= trial[W-1:0];
          quotient <= {quotient[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/xrr_datapath.sv */
// ----------------------------------------------------------------------------
// xrr_datapath
// Generator state, range arithmetic, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module xrr_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire xrr_pkg::in_item_t in_item,
  input  wire logic [63:0]      seed_low,
  input  wire logic [63:0]      seed_high,
  input  wire xrr_pkg::cmd_t    cmd,
  output xrr_pkg::stat_t        stat,
  output xrr_pkg::out_item_t    result
);
  import xrr_pkg::*;

  logic [1:0]  opcode;
  logic [63:0] start_v;
  logic [63:0] step_v;
  logic [63:0] span;
  logic [63:0] mag;
  logic [63:0] word_first;
  logic [63:0] word_second;
  logic [63:0] draw_r;
  logic [63:0] count;
  logic [63:0] a_val;
  logic [63:0] lim;
  logic [63:0] t0, t1, t2;
  logic [63:0] div_n, div_d, quot, div_rem;
  logic        div_done, rem_nz;
  logic [63:0] cnt_next;
  logic [63:0] res_next;
  logic        pow2;
  logic [63:0] bs, be, ustart, uend, ustep;
  logic [63:0] mul_acc, mul_a, mul_b, mul_pp;
  logic [3:0]  mul_cnt;
  logic        mul_busy, mul_done;

  assign ustart = in_item.range_start;
  assign uend = in_item.range_end;
  assign ustep = in_item.range_step;
  assign bs = ustart ^ {1'b1, 63'd0};
  assign be = uend ^ {1'b1, 63'd0};

  assign t0 = word_first ^ (word_first << SHIFT_A);
  assign t1 = t0 ^ (t0 >> SHIFT_B);
  assign t2 = t1 ^ word_second ^ (word_second >> SHIFT_C);

  always_comb begin
    unique case (cmd.div_src)
      DSRC_COUNT: begin div_n = span;      div_d = mag;   end
      DSRC_SCALE: begin div_n = '1;        div_d = count; end
      default:    begin div_n = draw_r;    div_d = a_val; end
    endcase
  end

  xrr_div #(.W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_n),
    .divisor(div_d), .done(div_done), .quotient(quot), .remainder(div_rem),
    .rem_nz(rem_nz)
  );

  assign cnt_next = quot + {63'd0, rem_nz};
  assign pow2 = ((count & (count - 64'd1)) == '0) && (step_v == 64'd1);

  // Four multiplier bits per cycle; only the low 64 product bits are kept.
  assign mul_pp = (mul_b[0] ? mul_a : '0) +
                  (mul_b[1] ? {mul_a[62:0], 1'b0} : '0) +
                  (mul_b[2] ? {mul_a[61:0], 2'b0} : '0) +
                  (mul_b[3] ? {mul_a[60:0], 3'b0} : '0);

  always_comb begin
    case (cmd.res_sel)
      RES_UNIT:   res_next = {11'd0, draw_r[FRAC_BITS-1:0]};
      RES_MASK:   res_next = start_v + (draw_r & (count - 64'd1));
      RES_SCALED: res_next = start_v + mul_acc;
      default:    res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
      mul_cnt <= '0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy <= 1'b1;
        mul_cnt <= 4'd15;
        mul_acc <= '0;
        mul_a <= step_v;
        mul_b <= quot;
      end else if (mul_busy) begin
        mul_acc <= mul_acc + mul_pp;
        mul_a <= {mul_a[59:0], 4'd0};
        mul_b <= {4'd0, mul_b[63:4]};
        mul_cnt <= mul_cnt - 4'd1;
        if (mul_cnt == 4'd0) begin
          mul_busy <= 1'b0;
          mul_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_first <= SEED_FIRST;
      word_second <= SEED_SECOND;
    end else if (cmd.reseed) begin
      word_first <= SEED_FIRST ^ seed_low;
      word_second <= SEED_SECOND ^ seed_high;
    end else if (cmd.draw) begin
      word_first <= word_second;
      word_second <= t2;
    end
    if (cmd.draw) draw_r <= t2 + word_second;
    if (cmd.load) begin
      opcode <= in_item.opcode;
      start_v <= ustart;
      step_v <= ustep;
      if (!ustep[63]) begin
        span <= (be < bs) ? '0 : uend - ustart;
        mag <= ustep;
      end else begin
        span <= (be > bs) ? '0 : ustart - uend;
        mag <= 64'd0 - ustep;
      end
    end
    if (cmd.count_cap) count <= cnt_next;
    if (cmd.a_cap) a_val <= quot;
    // a*count equals all-ones minus the remainder of all-ones / count.
    if (cmd.lim_cap) lim <= ~div_rem;
    if (cmd.res_cap) begin
      result.value <= res_next;
      result.status <= (cmd.res_sel == RES_ZSTEP) ? ST_ZERO_STEP :
                       (cmd.res_sel == RES_EMPTY) ? ST_EMPTY : ST_OK;
    end
  end

  assign stat.opcode = opcode;
  assign stat.step_zero = (step_v == '0);
  assign stat.count_zero = (count == '0);
  assign stat.pow2_unit = pow2;
  assign stat.div_done = div_done;
  assign stat.mul_done = mul_done;
  assign stat.reject = (draw_r >= lim);
endmodule
`default_nettype wire

/* rtl/xrr_ctrl.sv */
// ----------------------------------------------------------------------------
// xrr_ctrl
// Sequencer for reseed, unit and range commands and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module xrr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire xrr_pkg::stat_t stat,
  output xrr_pkg::cmd_t      cmd
);
  import xrr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_UNIT_DRAW, S_UNIT_RES, S_CNT_WAIT, S_CNT_CHK,
    S_MASK_DRAW, S_MASK_RES, S_A_WAIT, S_LIM, S_DRAW, S_CHECK, S_PICK_WAIT,
    S_MUL_WAIT, S_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.div_src = DSRC_COUNT;
    cmd.res_sel = RES_ZERO;
    cmd.load = accept;
    unique case (state)
      S_DECODE: begin
        unique case (stat.opcode)
          OP_RESEED: begin cmd.reseed = 1'b1; cmd.res_cap = 1'b1; end
          OP_UNIT:   cmd.draw = 1'b1;
          OP_RANGE: begin
            if (stat.step_zero) begin
              cmd.res_cap = 1'b1;
              cmd.res_sel = RES_ZSTEP;
            end else cmd.div_start = 1'b1;
          end
          default: cmd.res_cap = 1'b1;
        endcase
      end
      S_UNIT_DRAW: begin cmd.res_cap = 1'b1; cmd.res_sel = RES_UNIT; end
      S_CNT_WAIT: cmd.count_cap = stat.div_done;
      S_CNT_CHK: begin
        if (stat.count_zero) begin
          cmd.res_cap = 1'b1;
          cmd.res_sel = RES_EMPTY;
        end else if (stat.pow2_unit) cmd.draw = 1'b1;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_src = DSRC_SCALE;
        end
      end
      S_MASK_DRAW: begin cmd.res_cap = 1'b1; cmd.res_sel = RES_MASK; end
      S_A_WAIT: cmd.a_cap = stat.div_done;
      S_LIM: begin cmd.lim_cap = 1'b1; cmd.draw = 1'b1; end
      S_CHECK: begin
        if (stat.reject) cmd.draw = 1'b1;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_src = DSRC_PICK;
        end
      end
      S_PICK_WAIT: begin
        cmd.div_src = DSRC_PICK;
        cmd.mul_start = stat.div_done;
      end
      S_MUL_WAIT: begin
        cmd.res_sel = RES_SCALED;
        cmd.res_cap = stat.mul_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_DECODE;
        S_DECODE: begin
          if (stat.opcode == OP_UNIT) state <= S_UNIT_DRAW;
          else if (stat.opcode == OP_RANGE && !stat.step_zero) state <= S_CNT_WAIT;
          else begin state <= S_OUT; out_valid <= 1'b1; end
        end
        S_UNIT_DRAW: begin state <= S_OUT; out_valid <= 1'b1; end
        S_CNT_WAIT: if (stat.div_done) state <= S_CNT_CHK;
        S_CNT_CHK: begin
          if (stat.count_zero) begin state <= S_OUT; out_valid <= 1'b1; end
          else if (stat.pow2_unit) state <= S_MASK_DRAW;
          else state <= S_A_WAIT;
        end
        S_MASK_DRAW: begin state <= S_OUT; out_valid <= 1'b1; end
        S_A_WAIT: if (stat.div_done) state <= S_LIM;
        S_LIM: state <= S_CHECK;
        S_CHECK: if (!stat.reject) state <= S_PICK_WAIT;
        S_PICK_WAIT: if (stat.div_done) state <= S_MUL_WAIT;
        S_MUL_WAIT: if (stat.mul_done) begin state <= S_OUT; out_valid <= 1'b1; end
        S_OUT: if (!out_stall) begin state <= S_IDLE; out_valid <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/xorshift128plus_range_random.sv */
// ----------------------------------------------------------------------------
// xorshift128plus_range_random
// xorshift128+ source with reseed, unit-fraction and range draws.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | in_item (opcode, start, end, step)
// out     | output    | out_valid/stall | out_item (value, status)
// cfg     | input     | valid/ready     | cfg_index, cfg_data
//
// Reseed, zero step and the unused opcode finish without arithmetic; a unit draw
// advances the generator once. An empty range and a masked range draw each use
// one divider pass. A scaled range draw uses three passes of the shared
// bit-serial divider and a multiply, plus one redraw for each rejected draw.
// One item is in flight at a time; a stalled output holds off the next item.
// Reset is synchronous and restores the generator's seed constants.
// A stalled result holds in the output register until its transfer.
`default_nettype none
module xorshift128plus_range_random (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire xrr_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output xrr_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import xrr_pkg::*;
`include "assert_macros.svh"

  logic [63:0] seed_low;
  logic [63:0] seed_high;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_low <= '0;
      seed_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEED_LOW:  seed_low <= cfg_data;
        CFG_SEED_HIGH: seed_high <= cfg_data;
        default: ;
      endcase
    end
  end

  xrr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  xrr_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .seed_low(seed_low),
    .seed_high(seed_high), .cmd(cmd), .stat(stat), .result(out_item)
  );

  `ASSERT_IMPLY(a_no_accept_busy, clk, rst, out_valid, in_stall,
    "input accepted while a result is pending")
  `ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_item), "stalled result changed")
  `ASSERT_IMPLY(a_draw_not_reseed, clk, rst, cmd.draw, !cmd.reseed,
    "draw and reseed issued together")
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives reseed, unit, range and unused-opcode commands into the xorshift128+
// range generator under random source and sink stalls, and checks every
// result against a bit-exact prediction of the generator state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import xrr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  // Tracks the generator state and holds the results still owed by the block.
  class draw_scoreboard;
    logic [63:0] seed_lo, seed_hi;
    logic [63:0] word_a, word_b;
    out_item_t owed[$];
    int mismatches;

    function void clear();
      seed_lo = '0;
      seed_hi = '0;
      word_a = SEED_FIRST;
      word_b = SEED_SECOND;
      owed.delete();
      mismatches = 0;
    endfunction

    function logic [63:0] advance();
      logic [63:0] t;
      logic [63:0] s;
      t = word_a;
      s = word_b;
      word_a = s;
      t ^= t << SHIFT_A;
      t ^= t >> SHIFT_B;
      t ^= s ^ (s >> SHIFT_C);
      word_b = t;
      return t + s;
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t res;
      logic [63:0] st, en, sp, span, mag, count, a, lim, r;
      st = cmd.range_start;
      en = cmd.range_end;
      sp = cmd.range_step;
      res.value = '0;
      res.status = ST_OK;
      if (cmd.opcode == OP_RESEED) begin
        word_a = SEED_FIRST ^ seed_lo;
        word_b = SEED_SECOND ^ seed_hi;
      end else if (cmd.opcode == OP_UNIT) begin
        res.value = advance() & ((64'd1 << FRAC_BITS) - 1);
      end else if (cmd.opcode == OP_RANGE) begin
        if (sp == 0) begin
          res.status = ST_ZERO_STEP;
        end else begin
          if (!sp[63]) begin
            span = ($signed(en) < $signed(st)) ? 64'd0 : en - st;
            mag = sp;
          end else begin
            span = ($signed(en) > $signed(st)) ? 64'd0 : st - en;
            mag = -sp;
          end
          count = span / mag + ((span % mag != 0) ? 64'd1 : 64'd0);
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (sp == 64'd1 && (count & (count - 1)) == 0) begin
            res.value = st + (advance() & (count - 1));
          end else begin
            a = 64'hffff_ffff_ffff_ffff / count;
            lim = a * count;
            r = advance();
            while (r >= lim) r = advance();
            res.value = st + (r / a) * sp;
          end
        end
      end
      owed.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h status=%0d",
                                       got.value, got.status);
        return;
      end
      want = owed.pop_front();
      if (got.value !== want.value || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                   want.value, want.status, got.value, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  draw_scoreboard board;

  xorshift128plus_range_random uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sink side: random stall, result check on each transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_item);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SEED_LOW) board.seed_lo = data;
    else board.seed_hi = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high between back-to-back transfers; it drops only while idling or draining.
  task automatic send_command(in_item_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(cmd);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_small();
    return 64'($signed($urandom_range(200)) - 100);
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] op, logic [63:0] st,
                                        logic [63:0] en, logic [63:0] sp);
    in_item_t c;
    c.opcode = op;
    c.range_start = st;
    c.range_end = en;
    c.range_step = sp;
    return c;
  endfunction

  // Mostly range draws with modest spans; some full-width fields.
  function automatic in_item_t random_cmd();
    int pick;
    logic [63:0] st, en, sp;
    pick = $urandom_range(99);
    st = ($urandom_range(3) == 0) ? rand64() : rand_small();
    en = ($urandom_range(3) == 0) ? rand64() : st + rand_small() * 8;
    case ($urandom_range(5))
      0: sp = 64'd1;
      1: sp = 64'hffff_ffff_ffff_ffff;
      2: sp = rand64();
      3: sp = 64'd0;
      default: sp = rand_small();
    endcase
    if (pick < 4) return make_cmd(OP_RESEED, rand64(), rand64(), rand64());
    if (pick < 8) return make_cmd(2'd3, rand64(), rand64(), rand64());
    if (pick < 25) return make_cmd(OP_UNIT, rand64(), rand64(), rand64());
    return make_cmd(OP_RANGE, st, en, sp);
  endfunction

  localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  initial begin
    board = new();
    board.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset seed.
    send_command(make_cmd(OP_UNIT, 0, 0, 0));
    send_command(make_cmd(OP_RANGE, 0, 8, 1));
    send_command(make_cmd(OP_RANGE, 0, 10, 1));
    send_command(make_cmd(OP_RANGE, 5, 5, 1));
    send_command(make_cmd(OP_RANGE, 5, 0, 3));
    send_command(make_cmd(OP_RANGE, 0, 10, 0));
    send_command(make_cmd(OP_RANGE, 10, 0, -64'sd3));
    send_command(make_cmd(OP_RANGE, 0, 10, -64'sd1));
    send_command(make_cmd(OP_RANGE, MINN, MAXP, 1));
    send_command(make_cmd(OP_RANGE, MAXP, MINN, ONES));
    send_command(make_cmd(OP_RANGE, MINN, MAXP, MAXP));
    send_command(make_cmd(OP_RANGE, MAXP, MINN, MINN));
    send_command(make_cmd(OP_RANGE, 0, 1, 1));
    send_command(make_cmd(OP_RANGE, MINN, MAXP, 7));
    send_command(make_cmd(2'd3, ONES, ONES, ONES));
    send_command(make_cmd(OP_RESEED, ONES, ONES, ONES));
    send_command(make_cmd(OP_UNIT, ONES, MINN, 0));
    wait_drained();

    // Seed equal to the constants gives the all-zero state.
    write_reg(CFG_SEED_LOW, SEED_FIRST);
    write_reg(CFG_SEED_HIGH, SEED_SECOND);
    send_command(make_cmd(OP_RESEED, 0, 0, 0));
    send_command(make_cmd(OP_UNIT, 0, 0, 0));
    send_command(make_cmd(OP_RANGE, 0, 100, 3));
    wait_drained();

    // Random phases with different seeds and idling mixes.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 12; recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: begin write_reg(CFG_SEED_LOW, 0); write_reg(CFG_SEED_HIGH, 0); end
        1: begin write_reg(CFG_SEED_LOW, ONES); write_reg(CFG_SEED_HIGH, ONES); end
        default: begin
          write_reg(CFG_SEED_LOW, rand64());
          write_reg(CFG_SEED_HIGH, rand64());
        end
      endcase
      send_command(make_cmd(OP_RESEED, 0, 0, 0));
      for (int k = 0; k < 165; k++) send_command(random_cmd());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
